FILE: rtl/ick_pkg.sv
// ick_pkg: shared types, codes and arithmetic helpers for the internet checksum engine
// no dependencies; imported by ick_acc and internet_checksum_engine

package ick_pkg;

  localparam logic       KIND_HDR  = 1'b0;
  localparam logic       KIND_DATA = 1'b1;

  localparam logic [1:0] MODE_IPV4 = 2'd0;
  localparam logic [1:0] MODE_TCP  = 2'd1;
  localparam logic [1:0] MODE_UDP  = 2'd2;

  localparam logic [15:0] PROTO_TCP = 16'd6;
  localparam logic [15:0] PROTO_UDP = 16'd17;

  // checksum field position, in 16-bit words from the start of the packet
  localparam logic [3:0] CKPOS_IPV4 = 4'd5;
  localparam logic [3:0] CKPOS_TCP  = 4'd8;
  localparam logic [3:0] CKPOS_UDP  = 4'd3;
  // word index stops here, past every checksum position
  localparam logic [3:0] IDX_SAT    = 4'd9;

  localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;
  localparam logic [15:0] ALL_ONES       = 16'hFFFF;
  localparam logic [15:0] ALL_ZERO       = 16'h0000;

  typedef struct packed {
    logic        kind;
    logic [1:0]  mode;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] seg_length;
    logic [15:0] data_word;
    logic        odd_byte;
    logic        last;
  } ick_item_t;

  // one's-complement add with end-around carry, result stays 16 bits
  function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [3:0] ck_pos(input logic [1:0] mode);
    logic [3:0] p;
    case (mode)
      MODE_TCP: p = CKPOS_TCP;
      MODE_UDP: p = CKPOS_UDP;
      default:  p = CKPOS_IPV4;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/ick_acc.sv
// ick_acc: running one's-complement sum, word index and mode of the current packet
// uses ick_pkg; instantiated by internet_checksum_engine

module ick_acc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  ick_pkg::ick_item_t item_i,
  output logic              emit_o,
  output logic [15:0]       checksum_o
);
  import ick_pkg::*;

  logic [15:0] acc_q, acc_d;
  logic [3:0]  idx_q, idx_d;
  logic [1:0]  mode_q, mode_d;

  logic [18:0] ph_sum;
  logic [16:0] ph_fold1;
  logic [15:0] ph_fold2;
  logic [15:0] proto;
  logic [15:0] word;
  logic [15:0] nsum;
  logic [15:0] inv;

  // pseudo header: six words in one add, then two end-around folds
  always_comb begin
    proto    = (item_i.mode == MODE_TCP) ? PROTO_TCP : PROTO_UDP;
    ph_sum   = {3'd0, item_i.src_addr[31:16]} + {3'd0, item_i.src_addr[15:0]}
             + {3'd0, item_i.dst_addr[31:16]} + {3'd0, item_i.dst_addr[15:0]}
             + {3'd0, proto} + {3'd0, item_i.seg_length};
    ph_fold1 = {1'b0, ph_sum[15:0]} + {14'd0, ph_sum[18:16]};
    ph_fold2 = ph_fold1[15:0] + {15'd0, ph_fold1[16]};
  end

  always_comb begin
    word = item_i.odd_byte ? (item_i.data_word & HIGH_BYTE_MASK) : item_i.data_word;
    if (idx_q == ck_pos(mode_q)) begin
      word = ALL_ZERO;
    end
    nsum = add_ones(acc_q, word);
    inv  = ~nsum;
    if (mode_q == MODE_UDP && inv == ALL_ZERO) begin
      checksum_o = ALL_ONES;
    end else begin
      checksum_o = inv;
    end
    emit_o = (item_i.kind == KIND_DATA) && item_i.last;
  end

  always_comb begin
    acc_d  = acc_q;
    idx_d  = idx_q;
    mode_d = mode_q;
    if (adv_i) begin
      if (item_i.kind == KIND_HDR) begin
        mode_d = item_i.mode;
        idx_d  = '0;
        if (item_i.mode == MODE_TCP || item_i.mode == MODE_UDP) begin
          acc_d = ph_fold2;
        end else begin
          acc_d = '0;
        end
      end else if (item_i.last) begin
        acc_d = '0;
        idx_d = '0;
      end else begin
        acc_d = nsum;
        if (idx_q != IDX_SAT) begin
          idx_d = idx_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      idx_q  <= '0;
      mode_q <= MODE_IPV4;
    end else begin
      acc_q  <= acc_d;
      idx_q  <= idx_d;
      mode_q <= mode_d;
    end
  end

endmodule

FILE: rtl/internet_checksum_engine.sv
// internet_checksum_engine: IPv4 / TCP / UDP one's-complement checksum over a word stream
// uses ick_pkg and ick_acc
// result: the last data word is held in the input register, then its checksum in the output register
// throughput: one word per cycle, but a last data word waits on a stalled result; the input
// register feeds one end-around-carry add into the output register; other words pass even then
// reset: asynchronous, clears valids, sum, word index and mode (IPv4)

module internet_checksum_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [1:0]  mode_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] seg_length_i,
  input  logic [15:0] data_word_i,
  input  logic        odd_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] checksum_o
);
  import ick_pkg::*;

  logic        in_vld_q;
  ick_item_t   item_q;
  logic        out_vld_q;
  logic [15:0] cks_q;
  logic        adv;
  logic        emit;
  logic [15:0] cks;
  logic        in_acc;

  ick_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .item_i     (item_q),
    .emit_o     (emit),
    .checksum_o (cks)
  );

  // a word that yields no result never waits on the output side
  assign adv        = in_vld_q && (!emit || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv && emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.kind       <= kind_i;
      item_q.mode       <= mode_i;
      item_q.src_addr   <= src_addr_i;
      item_q.dst_addr   <= dst_addr_i;
      item_q.seg_length <= seg_length_i;
      item_q.data_word  <= data_word_i;
      item_q.odd_byte   <= odd_byte_i;
      item_q.last       <= last_i;
    end
    if (adv && emit) begin
      cks_q <= cks;
    end
  end

  assign out_valid_o = out_vld_q;
  assign checksum_o  = cks_q;

  a_stall_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with no word held");

  a_no_result_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && emit) |-> !(out_vld_q && out_stall_i))
    else $error("result issued over a stalled result");

  a_result_from_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q && emit))
    else $error("result appeared without a last data word");

endmodule

FILE: test/internet_checksum_engine_test.sv
// internet_checksum_engine_test: self-checking bench for the ipv4/tcp/udp checksum engine
// drives header and data words under random gaps and stalls, checks each checksum in order
// depends on ick_pkg and internet_checksum_engine

`timescale 1ns / 100ps

module internet_checksum_engine_test;
  import ick_pkg::*;

  localparam logic [1:0] MODE_RSVD   = 2'd3;
  localparam int         ITEM_TARGET = 2000;
  localparam int         LONG_WORDS  = 200;
  localparam int         CYCLE_LIMIT = 1000000;

  typedef struct {
    ick_item_t   it;
    bit          typed;
    logic [15:0] want;
  } stim_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic        kind_i       = 1'b0;
  logic [1:0]  mode_i       = 2'd0;
  logic [31:0] src_addr_i   = 32'd0;
  logic [31:0] dst_addr_i   = 32'd0;
  logic [15:0] seg_length_i = 16'd0;
  logic [15:0] data_word_i  = 16'd0;
  logic        odd_byte_i   = 1'b0;
  logic        last_i       = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [15:0] checksum_o;

  // typed-in expectation travels with the word it belongs to
  bit          pin_typed = 1'b0;
  logic [15:0] pin_want  = 16'd0;

  // checksum model state
  logic [31:0] sum_acc  = 32'd0;
  logic [15:0] word_idx = 16'd0;
  logic [1:0]  cur_mode = MODE_IPV4;

  logic [15:0] awaited_checksums[$];
  stim_row_t   script[$];
  int          mismatches    = 0;
  int          cycle_count   = 0;
  int          items_sent    = 0;
  int          results_seen  = 0;
  int          results_paced = 0;
  int          rx_wait       = 0;
  int          tx_gap_max    = 3;
  int          rx_gap_max    = 3;

  internet_checksum_engine dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] ones_add(input logic [31:0] acc, input logic [15:0] w);
    logic [31:0] s;
    s = acc + {16'd0, w};
    return {16'd0, s[15:0]} + {16'd0, s[31:16]};
  endfunction

  function automatic logic [15:0] fold16(input logic [31:0] s);
    while (s[31:16] != 16'd0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return s[15:0];
  endfunction

  function automatic logic [15:0] csum_pos(input logic [1:0] m);
    if (m == MODE_TCP) return {12'd0, CKPOS_TCP};
    if (m == MODE_UDP) return {12'd0, CKPOS_UDP};
    return {12'd0, CKPOS_IPV4};
  endfunction

  task automatic absorb_item(input ick_item_t it, output bit produced, output logic [15:0] csum);
    logic [15:0] w;
    logic [31:0] s;
    produced = 1'b0;
    csum = ALL_ZERO;
    if (it.kind == KIND_HDR) begin
      cur_mode = it.mode;
      sum_acc = 32'd0;
      word_idx = 16'd0;
      if (it.mode == MODE_TCP || it.mode == MODE_UDP) begin
        // pseudo header
        s = ones_add(32'd0, it.src_addr[31:16]);
        s = ones_add(s, it.src_addr[15:0]);
        s = ones_add(s, it.dst_addr[31:16]);
        s = ones_add(s, it.dst_addr[15:0]);
        s = ones_add(s, (it.mode == MODE_TCP) ? PROTO_TCP : PROTO_UDP);
        s = ones_add(s, it.seg_length);
        sum_acc = s;
      end
    end else begin
      w = it.odd_byte ? (it.data_word & HIGH_BYTE_MASK) : it.data_word;
      if (word_idx == csum_pos(cur_mode)) w = ALL_ZERO;
      sum_acc = ones_add(sum_acc, w);
      if (word_idx != ALL_ONES) word_idx = word_idx + 16'd1;
      if (it.last) begin
        csum = ~fold16(sum_acc);
        if (cur_mode == MODE_UDP && csum == ALL_ZERO) csum = ALL_ONES;
        produced = 1'b1;
        sum_acc = 32'd0;
        word_idx = 16'd0;
      end
    end
  endtask

  function automatic ick_item_t make_header(input logic [1:0] m, input logic [31:0] src,
                                            input logic [31:0] dst, input logic [15:0] len);
    ick_item_t it;
    it.kind       = KIND_HDR;
    it.mode       = m;
    it.src_addr   = src;
    it.dst_addr   = dst;
    it.seg_length = len;
    it.data_word  = 16'($urandom);
    it.odd_byte   = 1'($urandom);
    it.last       = 1'($urandom);
    return it;
  endfunction

  function automatic ick_item_t make_data(input logic [15:0] w, input bit odd, input bit fin);
    ick_item_t it;
    it.kind       = KIND_DATA;
    it.mode       = 2'($urandom);
    it.src_addr   = $urandom;
    it.dst_addr   = $urandom;
    it.seg_length = 16'($urandom);
    it.data_word  = w;
    it.odd_byte   = odd;
    it.last       = fin;
    return it;
  endfunction

  task automatic add_row(input ick_item_t it, input bit typed, input logic [15:0] want);
    stim_row_t r;
    r.it = it;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endtask

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_item(input ick_item_t it, input bit typed, input logic [15:0] want);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i       <= it.kind;
    mode_i       <= it.mode;
    src_addr_i   <= it.src_addr;
    dst_addr_i   <= it.dst_addr;
    seg_length_i <= it.seg_length;
    data_word_i  <= it.data_word;
    odd_byte_i   <= it.odd_byte;
    last_i       <= it.last;
    pin_typed    <= typed;
    pin_want     <= want;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (awaited_checksums.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_packet();
    int          n;
    int          pick;
    logic [1:0]  m;
    logic [15:0] w;
    logic [127:0] noise_bits;
    bit          odd;
    bit          fin;
    bit          cut;
    bit          to_zero;
    tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
    rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // stray word with every field random
      noise_bits = {$urandom, $urandom, $urandom, $urandom};
      send_item(noise_bits[100:0], 1'b0, ALL_ZERO);
      return;
    end
    // some packets continue in the previous mode without a header
    if (pick >= 14) begin
      case ($urandom_range(0, 9))
        0, 1, 2: m = MODE_IPV4;
        3, 4, 5: m = MODE_TCP;
        6, 7, 8: m = MODE_UDP;
        default: m = MODE_RSVD;
      endcase
      send_item(make_header(m, $urandom, $urandom, 16'($urandom)), 1'b0, ALL_ZERO);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) n = $urandom_range(1, 12);
    else if (pick < 95) n = $urandom_range(13, 40);
    else n = $urandom_range(41, 200);
    cut = ($urandom_range(0, 19) == 0);
    to_zero = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < n; i++) begin
      fin = (i == n - 1) && !cut;
      w = 16'($urandom);
      odd = fin ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 19) == 0);
      // steer the sum to all ones so the result is zero, or 0xffff in udp
      if (fin && to_zero && word_idx != csum_pos(cur_mode)) begin
        w = ~fold16(sum_acc);
        odd = 1'b0;
      end
      send_item(make_data(w, odd, fin), 1'b0, ALL_ZERO);
    end
  endtask

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    ick_item_t   seen;
    bit          got_result;
    logic [15:0] predicted;
    logic [15:0] want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("internet_checksum_engine test failed");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (awaited_checksums.size() == 0) begin
          report($sformatf("unexpected checksum %h", checksum_o));
        end else begin
          want = awaited_checksums.pop_front();
          if (want !== checksum_o)
            report($sformatf("checksum mismatch: expected %h got %h", want, checksum_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        seen = {kind_i, mode_i, src_addr_i, dst_addr_i, seg_length_i, data_word_i,
                odd_byte_i, last_i};
        absorb_item(seen, got_result, predicted);
        if (got_result) awaited_checksums.push_back(pin_typed ? pin_want : predicted);
      end
    end
  end

  // receiver: a fresh stall length after every accepted result
  always @(negedge clk_i) begin
    if (results_seen != results_paced) begin
      results_paced = results_seen;
      rx_wait = $urandom_range(0, rx_gap_max);
    end
    if (rx_wait != 0) begin
      out_stall_i <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ipv4 straight out of reset
    add_row(make_data(16'h0000, 1'b0, 1'b1), 1'b1, 16'hFFFF);
    add_row(make_data(16'hFFFF, 1'b0, 1'b1), 1'b1, 16'h0000);
    // udp whose checksum comes to zero is sent as all ones
    add_row(make_header(MODE_UDP, 32'h0000_0000, 32'h0000_0000, 16'h0000), 1'b0, ALL_ZERO);
    add_row(make_data(16'hFFEE, 1'b0, 1'b1), 1'b1, 16'hFFFF);
    // next packet keeps udp but has no pseudo header
    add_row(make_data(16'hFFEE, 1'b0, 1'b1), 1'b1, 16'h0011);
    add_row(make_header(MODE_TCP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), 1'b0, ALL_ZERO);
    add_row(make_data(16'hFFFF, 1'b0, 1'b0), 1'b0, ALL_ZERO);
    add_row(make_data(16'h0000, 1'b1, 1'b1), 1'b0, ALL_ZERO);
    // ipv4 checksum field at word 5 is skipped
    add_row(make_header(MODE_IPV4, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF), 1'b0, ALL_ZERO);
    repeat (5) add_row(make_data(16'h0001, 1'b0, 1'b0), 1'b0, ALL_ZERO);
    add_row(make_data(16'hFFFF, 1'b0, 1'b1), 1'b1, 16'hFFFA);
    add_row(make_data(16'h12FF, 1'b1, 1'b1), 1'b1, 16'hEDFF);
    // reserved mode, odd byte mid packet, then a header cuts the packet short
    add_row(make_header(MODE_RSVD, 32'h0102_0304, 32'hA0B0_C0D0, 16'h0044), 1'b0, ALL_ZERO);
    add_row(make_data(16'hABCD, 1'b1, 1'b0), 1'b0, ALL_ZERO);
    add_row(make_data(16'h1234, 1'b0, 1'b0), 1'b0, ALL_ZERO);
    add_row(make_header(MODE_UDP, 32'h1234_5678, 32'h9ABC_DEF0, 16'h0010), 1'b0, ALL_ZERO);
    add_row(make_data(16'h4500, 1'b0, 1'b0), 1'b0, ALL_ZERO);
    add_row(make_data(16'h0030, 1'b0, 1'b0), 1'b0, ALL_ZERO);
    add_row(make_data(16'hBEEF, 1'b0, 1'b0), 1'b0, ALL_ZERO);
    add_row(make_data(16'hFFFF, 1'b0, 1'b1), 1'b0, ALL_ZERO);

    foreach (script[i]) send_item(script[i].it, script[i].typed, script[i].want);
    drain();

    while (items_sent < ITEM_TARGET) send_packet();
    drain();

    // one long packet sent back to back, well past the last checksum position
    tx_gap_max = 0;
    rx_gap_max = 0;
    send_item(make_header(MODE_UDP, $urandom, $urandom, 16'($urandom)), 1'b0, ALL_ZERO);
    for (int i = 0; i < LONG_WORDS; i++)
      send_item(make_data(16'($urandom), (i == LONG_WORDS - 1) && ($urandom_range(0, 1) == 1),
                          i == LONG_WORDS - 1), 1'b0, ALL_ZERO);
    drain();

    repeat (16) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("internet_checksum_engine test passed");
    end else begin
      $display("internet_checksum_engine test failed");
    end
    $finish;
  end

endmodule
